// ===== src/tbq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbq_pkg
// Shared types, fixed-point constants and pipeline depths for the trackball
// rotation quaternion block.
// ----------------------------------------------------------------------------
package tbq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int RAD_W     = 15;
	localparam logic [RAD_W-1:0] RAD_RESET = 15'd13107;
	localparam logic signed [15:0] Q_ONE = 16'(1 << FRAC_BITS);
	localparam logic [29:0] ONE_SQ = 30'(1) << (2 * FRAC_BITS);

	// square root and divider widths; every unit resolves one bit per stage
	localparam int SPH_SQ_W  = 30;
	localparam int SSQ_LAT   = SPH_SQ_W / 2 + 1;
	localparam int HYP_SQ_W  = 62;
	localparam int HSQ_LAT   = HYP_SQ_W / 2 + 1;
	localparam int HYP_NUM_W = 46;
	localparam int LIFT_LAT  = HSQ_LAT + HYP_NUM_W + 1;

	localparam int DST_SQ_W  = 62;
	localparam int DSQ_LAT   = DST_SQ_W / 2 + 1;
	localparam int T_NUM_W   = 47;
	localparam int T_LAT     = DSQ_LAT + T_NUM_W + 1;

	localparam int ASQ_W     = 64;
	localparam int ASQ_LAT   = ASQ_W / 2 + 1;

	localparam int Q_NUM_W   = 48;
	localparam int W_SQ_W    = 30;
	localparam int WSQ_LAT   = W_SQ_W / 2 + 1;

	localparam int T_STAGE   = 5 + LIFT_LAT + T_LAT;
	localparam int PIPE_LAT  = T_STAGE + 2 + Q_NUM_W + 1;

	typedef struct packed {
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
	} tbq_point_t;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic               no_rotation;
	} tbq_quat_t;

endpackage

// ===== src/tbq_sqrt.sv =====
// ----------------------------------------------------------------------------
// tbq_sqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest
// in a final stage.
// ----------------------------------------------------------------------------
module tbq_sqrt #(
	parameter int W = 30
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W/2:0] root
);

	localparam int N  = W / 2;
	localparam int RW = N + 3;

	logic [W-1:0]  rad_sn  [1:N-1];
	logic [RW-1:0] rem_sn  [1:N];
	logic [N-1:0]  root_sn [1:N];
	logic [N:0]    root_q;

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [W-1:0]  rad_in;
		logic [RW-1:0] rem_in;
		logic [N-1:0]  root_in;
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;

		if (k == 1) begin : g_first
			assign rad_in  = d;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_sn[k-1];
			assign rem_in  = rem_sn[k-1];
			assign root_in = root_sn[k-1];
		end

		assign rem_sh = {rem_in[RW-3:0], rad_in[W-1:W-2]};
		assign trial  = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= trial) begin
					rem_sn[k]  <= rem_sh - trial;
					root_sn[k] <= {root_in[N-2:0], 1'b1};
				end else begin
					rem_sn[k]  <= rem_sh;
					root_sn[k] <= {root_in[N-2:0], 1'b0};
				end
			end
		end

		if (k < N) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_sn[k] <= rad_in << 2;
				end
			end
		end
	end

	// round up when the remainder exceeds the root
	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= {1'b0, root_sn[N]} +
				{{N{1'b0}}, (rem_sn[N] > {3'b000, root_sn[N]})};
		end
	end

	assign root = root_q;

endmodule

// ===== src/tbq_div.sv =====
// ----------------------------------------------------------------------------
// tbq_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbq_div #(
	parameter int NW = 46,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [NW-1:0] num_sn [1:NW];
	logic [DW-1:0] rem_sn [1:NW-1];
	logic [DW-1:0] den_sn [1:NW-1];

	for (genvar k = 1; k <= NW; k++) begin : g_step
		logic [NW-1:0] num_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   rem_sh;
		logic [DW:0]   rem_sub;
		logic          ge;

		if (k == 1) begin : g_first
			assign num_in = num;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign num_in = num_sn[k-1];
			assign rem_in = rem_sn[k-1];
			assign den_in = den_sn[k-1];
		end

		assign rem_sh  = {rem_in, num_in[NW-1]};
		assign ge      = rem_sh >= {1'b0, den_in};
		assign rem_sub = rem_sh - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				num_sn[k] <= {num_in[NW-2:0], ge};
			end
		end

		if (k < NW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sn[k] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
					den_sn[k] <= den_in;
				end
			end
		end
	end

	assign quo = num_sn[NW];

endmodule

// ===== src/tbq_delay.sv =====
// ----------------------------------------------------------------------------
// tbq_delay
// Stallable delay line that keeps side data aligned with the arithmetic
// units.
// ----------------------------------------------------------------------------
module tbq_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_sn [1:D];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_sn[1] <= d;
			for (int k = 2; k <= D; k++) begin
				pipe_sn[k] <= pipe_sn[k-1];
			end
		end
	end

	assign q = pipe_sn[D];

endmodule

// ===== src/tbq_lift.sv =====
// ----------------------------------------------------------------------------
// tbq_lift
// Lifts one pointer onto the trackball surface: sphere height inside
// radius/sqrt2, hyperbola height at or beyond it.
// ----------------------------------------------------------------------------
module tbq_lift (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] d2,
	input  logic [29:0] r2,
	output logic [15:0] z
);

	localparam int DNW = tbq_pkg::HYP_SQ_W / 2 + 1;

	logic            in_sph;
	logic            in_sph_d;
	logic [15:0]     sph_root;
	logic [15:0]     sph_d;
	logic [DNW-1:0]  dn;
	logic            dn_zero_d;
	logic [tbq_pkg::HYP_NUM_W-1:0] hyp_quo;
	logic [15:0]     z_q;

	assign in_sph = {d2, 1'b0} < {3'b000, r2};

	tbq_sqrt #(.W(tbq_pkg::SPH_SQ_W)) u_sph (
		.clk  (clk),
		.en   (en),
		.d    (r2 - d2[29:0]),
		.root (sph_root)
	);

	tbq_sqrt #(.W(tbq_pkg::HYP_SQ_W)) u_hyp (
		.clk  (clk),
		.en   (en),
		.d    ({d2, 30'b0}),
		.root (dn)
	);

	// (r^2 * 2^15 + dn) / (2 dn)
	tbq_div #(.NW(tbq_pkg::HYP_NUM_W), .DW(DNW + 1)) u_div (
		.clk (clk),
		.en  (en),
		.num ({1'b0, r2, 15'b0} + {14'b0, dn}),
		.den ({dn, 1'b0}),
		.quo (hyp_quo)
	);

	tbq_delay #(.W(1), .D(tbq_pkg::LIFT_LAT - 1)) u_in_dly (
		.clk (clk), .en (en), .d (in_sph), .q (in_sph_d)
	);

	tbq_delay #(
		.W(16),
		.D(tbq_pkg::HSQ_LAT + tbq_pkg::HYP_NUM_W - tbq_pkg::SSQ_LAT)
	) u_sph_dly (
		.clk (clk), .en (en), .d (sph_root), .q (sph_d)
	);

	tbq_delay #(.W(1), .D(tbq_pkg::HYP_NUM_W)) u_dz_dly (
		.clk (clk), .en (en), .d (dn == '0), .q (dn_zero_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (in_sph_d) begin
				z_q <= sph_d;
			end else if (dn_zero_d) begin
				z_q <= '0;
			end else begin
				z_q <= hyp_quo[15:0];
			end
		end
	end

	assign z = z_q;

endmodule

// ===== src/trackball_rotation_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// trackball_rotation_quaternion_top
// Virtual trackball: two pointer positions in, rotation quaternion out.
// ----------------------------------------------------------------------------
// datapath: request to result runs through a chain of bit-per-stage square roots
//   and dividers (lift, distance, normalize)
// throughput: one request per cycle; a stalled output holds the whole pipe
// reset: pipeline empty, ball radius 0.8 (13107)
module trackball_rotation_quaternion_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	output logic                point_ready,
	input  tbq_pkg::tbq_point_t point,
	output logic                quat_valid,
	input  logic                quat_ready,
	output tbq_pkg::tbq_quat_t  quat,
	input  logic                radius_we,
	input  logic [14:0]         radius_wdata
);

	localparam int L = tbq_pkg::PIPE_LAT;

	typedef struct packed {
		tbq_pkg::tbq_point_t pt;
		logic                eq;
	} side_a_t;

	typedef struct packed {
		logic [31:0] am0;
		logic [31:0] am1;
		logic [31:0] am2;
		logic [2:0]  an;
		logic        ident;
	} side_t_t;

	typedef struct packed {
		logic [2:0] an;
		logic       ident;
	} side_q_t;

	function automatic logic [31:0] abs34(input logic signed [33:0] v);
		logic signed [33:0] n;
		n = -v;
		return v[33] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic signed [15:0] qcomp(input logic [47:0] qv, input logic neg);
		logic [15:0] c;
		c = (qv > 48'(tbq_pkg::Q_ONE)) ? tbq_pkg::Q_ONE : qv[15:0];
		return neg ? c : -c;
	endfunction

	logic                en;
	logic [L:1]          vld_q;
	logic [14:0]         radius_q;
	logic [29:0]         r2_q;

	tbq_pkg::tbq_point_t pt_s1;
	tbq_pkg::tbq_point_t pt_s2;
	logic [31:0]         d2a_s2;
	logic [31:0]         d2b_s2;
	logic                eq_s2;
	logic signed [31:0]  psx;
	logic signed [31:0]  psy;
	logic signed [31:0]  pex;
	logic signed [31:0]  pey;

	logic [15:0]         za;
	logic [15:0]         zb;
	side_a_t             side_a;

	logic signed [16:0]  z1s;
	logic signed [16:0]  z2s;
	logic signed [33:0]  p_y2z1, p_z2y1, p_z2x1, p_x2z1, p_x2y1, p_y2x1;
	logic signed [33:0]  ax0_s3, ax1_s3, ax2_s3;
	logic signed [16:0]  dx_s3, dy_s3, dz_s3;
	logic                eq_s3;

	logic signed [67:0]  pa0, pa1, pa2;
	logic signed [33:0]  pdx, pdy, pdz;
	logic [63:0]         sq0_s4, sq1_s4, sq2_s4;
	logic [33:0]         ddx_s4, ddy_s4, ddz_s4;
	logic [31:0]         am0_s4, am1_s4, am2_s4;
	logic [2:0]          an_s4;
	logic                eq_s4;

	logic [63:0]         asq_s5;
	logic [34:0]         dd_s5;
	logic [31:0]         am0_s5, am1_s5, am2_s5;
	logic [2:0]          an_s5;
	logic                eq_s5;

	logic [32:0]         alen;
	logic [32:0]         alen_d;
	logic                far;
	logic                far_d;
	logic [31:0]         dist_root;
	logic [tbq_pkg::T_NUM_W-1:0] t_quo;
	side_t_t             side_t_in;
	side_t_t             side_t;
	logic [14:0]         t_s6;

	logic [46:0]         p0_s7, p1_s7, p2_s7;
	logic [29:0]         tsq_s7;
	logic [32:0]         alen_s7;
	side_q_t             side_s7;

	logic [47:0]         num0_s8, num1_s8, num2_s8;
	logic [32:0]         den_s8;
	logic [29:0]         warg_s8;
	side_q_t             side_s8;

	logic [47:0]         quo0, quo1, quo2;
	logic [15:0]         wroot;
	logic [15:0]         wroot_d;
	side_q_t             side_q;
	tbq_pkg::tbq_quat_t  quat_s9;

	assign en          = !vld_q[L] || quat_ready;
	assign point_ready = en;
	assign quat_valid  = vld_q[L];
	assign quat        = quat_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			radius_q <= tbq_pkg::RAD_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[L-1:1], point_valid};
			end
			if (radius_we) begin
				radius_q <= radius_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= radius_q * radius_q;
	end

	// squared distances from the center
	assign psx = pt_s1.start_x * pt_s1.start_x;
	assign psy = pt_s1.start_y * pt_s1.start_y;
	assign pex = pt_s1.end_x * pt_s1.end_x;
	assign pey = pt_s1.end_y * pt_s1.end_y;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1  <= point;
			pt_s2  <= pt_s1;
			d2a_s2 <= $unsigned(psx) + $unsigned(psy);
			d2b_s2 <= $unsigned(pex) + $unsigned(pey);
			eq_s2  <= (pt_s1.start_x == pt_s1.end_x) && (pt_s1.start_y == pt_s1.end_y);
		end
	end

	tbq_lift u_lift_a (.clk (clk), .en (en), .d2 (d2a_s2), .r2 (r2_q), .z (za));
	tbq_lift u_lift_b (.clk (clk), .en (en), .d2 (d2b_s2), .r2 (r2_q), .z (zb));

	tbq_delay #(.W($bits(side_a_t)), .D(tbq_pkg::LIFT_LAT)) u_side_a (
		.clk (clk), .en (en), .d ({pt_s2, eq_s2}), .q (side_a)
	);

	// axis = end x start
	assign z1s    = $signed({1'b0, za});
	assign z2s    = $signed({1'b0, zb});
	assign p_y2z1 = side_a.pt.end_y * z1s;
	assign p_z2y1 = z2s * side_a.pt.start_y;
	assign p_z2x1 = z2s * side_a.pt.start_x;
	assign p_x2z1 = side_a.pt.end_x * z1s;
	assign p_x2y1 = side_a.pt.end_x * side_a.pt.start_y;
	assign p_y2x1 = side_a.pt.end_y * side_a.pt.start_x;

	assign pa0 = ax0_s3 * ax0_s3;
	assign pa1 = ax1_s3 * ax1_s3;
	assign pa2 = ax2_s3 * ax2_s3;
	assign pdx = dx_s3 * dx_s3;
	assign pdy = dy_s3 * dy_s3;
	assign pdz = dz_s3 * dz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s3 <= p_y2z1 - p_z2y1;
			ax1_s3 <= p_z2x1 - p_x2z1;
			ax2_s3 <= p_x2y1 - p_y2x1;
			dx_s3  <= side_a.pt.start_x - side_a.pt.end_x;
			dy_s3  <= side_a.pt.start_y - side_a.pt.end_y;
			dz_s3  <= z1s - z2s;
			eq_s3  <= side_a.eq;

			sq0_s4 <= pa0[63:0];
			sq1_s4 <= pa1[63:0];
			sq2_s4 <= pa2[63:0];
			ddx_s4 <= pdx;
			ddy_s4 <= pdy;
			ddz_s4 <= pdz;
			am0_s4 <= abs34(ax0_s3);
			am1_s4 <= abs34(ax1_s3);
			am2_s4 <= abs34(ax2_s3);
			an_s4  <= {ax2_s3[33], ax1_s3[33], ax0_s3[33]};
			eq_s4  <= eq_s3;

			asq_s5 <= sq0_s4 + sq1_s4 + sq2_s4;
			dd_s5  <= {1'b0, ddx_s4} + {1'b0, ddy_s4} + {1'b0, ddz_s4};
			am0_s5 <= am0_s4;
			am1_s5 <= am1_s4;
			am2_s5 <= am2_s4;
			an_s5  <= an_s4;
			eq_s5  <= eq_s4;
		end
	end

	tbq_sqrt #(.W(tbq_pkg::ASQ_W)) u_alen (
		.clk (clk), .en (en), .d (asq_s5), .root (alen)
	);

	tbq_delay #(.W(33), .D(tbq_pkg::T_LAT - tbq_pkg::ASQ_LAT)) u_alen_dly (
		.clk (clk), .en (en), .d (alen), .q (alen_d)
	);

	// t = |start - end| / (2r), saturating at one
	assign far = (radius_q == '0) || ({1'b0, dd_s5} >= {4'b0000, r2_q, 2'b00});

	tbq_sqrt #(.W(tbq_pkg::DST_SQ_W)) u_dist (
		.clk (clk), .en (en), .d ({dd_s5[33:0], 28'b0}), .root (dist_root)
	);

	tbq_div #(.NW(tbq_pkg::T_NUM_W), .DW(30)) u_tdiv (
		.clk (clk),
		.en  (en),
		.num ({{1'b0, dist_root} + {18'b0, radius_q}, 14'b0}),
		.den ({radius_q, 15'b0}),
		.quo (t_quo)
	);

	tbq_delay #(.W(1), .D(tbq_pkg::T_LAT - 1)) u_far_dly (
		.clk (clk), .en (en), .d (far), .q (far_d)
	);

	assign side_t_in = '{am0: am0_s5, am1: am1_s5, am2: am2_s5, an: an_s5,
		ident: eq_s5 || (asq_s5 == '0)};

	tbq_delay #(.W($bits(side_t_t)), .D(tbq_pkg::T_LAT)) u_side_t (
		.clk (clk), .en (en), .d (side_t_in), .q (side_t)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (far_d || (t_quo > 47'(tbq_pkg::Q_ONE))) begin
				t_s6 <= tbq_pkg::Q_ONE[14:0];
			end else begin
				t_s6 <= t_quo[14:0];
			end

			p0_s7   <= t_s6 * side_t.am0;
			p1_s7   <= t_s6 * side_t.am1;
			p2_s7   <= t_s6 * side_t.am2;
			tsq_s7  <= t_s6 * t_s6;
			alen_s7 <= alen_d;
			side_s7 <= '{an: side_t.an, ident: side_t.ident};

			num0_s8 <= {1'b0, p0_s7} + {16'b0, alen_s7[32:1]};
			num1_s8 <= {1'b0, p1_s7} + {16'b0, alen_s7[32:1]};
			num2_s8 <= {1'b0, p2_s7} + {16'b0, alen_s7[32:1]};
			den_s8  <= alen_s7;
			warg_s8 <= tbq_pkg::ONE_SQ - tsq_s7;
			side_s8 <= side_s7;
		end
	end

	tbq_div #(.NW(tbq_pkg::Q_NUM_W), .DW(33)) u_qdiv0 (
		.clk (clk), .en (en), .num (num0_s8), .den (den_s8), .quo (quo0)
	);
	tbq_div #(.NW(tbq_pkg::Q_NUM_W), .DW(33)) u_qdiv1 (
		.clk (clk), .en (en), .num (num1_s8), .den (den_s8), .quo (quo1)
	);
	tbq_div #(.NW(tbq_pkg::Q_NUM_W), .DW(33)) u_qdiv2 (
		.clk (clk), .en (en), .num (num2_s8), .den (den_s8), .quo (quo2)
	);

	tbq_sqrt #(.W(tbq_pkg::W_SQ_W)) u_wsqrt (
		.clk (clk), .en (en), .d (warg_s8), .root (wroot)
	);

	tbq_delay #(.W(16), .D(tbq_pkg::Q_NUM_W - tbq_pkg::WSQ_LAT)) u_w_dly (
		.clk (clk), .en (en), .d (wroot), .q (wroot_d)
	);

	tbq_delay #(.W($bits(side_q_t)), .D(tbq_pkg::Q_NUM_W)) u_side_q (
		.clk (clk), .en (en), .d (side_s8), .q (side_q)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_q.ident) begin
				quat_s9.quat_x      <= '0;
				quat_s9.quat_y      <= '0;
				quat_s9.quat_z      <= '0;
				quat_s9.quat_w      <= tbq_pkg::Q_ONE;
				quat_s9.no_rotation <= 1'b1;
			end else begin
				quat_s9.quat_x      <= qcomp(quo0, side_q.an[0]);
				quat_s9.quat_y      <= qcomp(quo1, side_q.an[1]);
				quat_s9.quat_z      <= qcomp(quo2, side_q.an[2]);
				quat_s9.quat_w      <= (wroot_d > tbq_pkg::Q_ONE) ? tbq_pkg::Q_ONE : wroot_d;
				quat_s9.no_rotation <= 1'b0;
			end
		end
	end

	// t never leaves [0, 1]
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[tbq_pkg::T_STAGE] |-> t_s6 <= tbq_pkg::Q_ONE[14:0])
		else $error("t above one");

	// scalar part stays within [0, 1]
	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> !quat.quat_w[15] && quat.quat_w <= tbq_pkg::Q_ONE)
		else $error("w out of range");

	// x component of the vector part saturates at one
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> quat.quat_x <= tbq_pkg::Q_ONE && quat.quat_x >= -tbq_pkg::Q_ONE)
		else $error("x out of range");

	// identity results carry a zero vector part and unit scalar
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat.no_rotation |-> quat.quat_x == '0 && quat.quat_y == '0 &&
			quat.quat_z == '0 && quat.quat_w == tbq_pkg::Q_ONE)
		else $error("bad identity");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the trackball rotation quaternion block. A
// scoreboard predicts each quaternion from the accepted point pair and the
// current ball radius, and compares the results in order. Directed pairs
// cover extremes and identity cases, then random drags run over several
// radii with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
class quat_scoreboard;
	tbq_pkg::tbq_quat_t pending[$];
	logic [14:0] radius;
	int errors;
	int checked;

	function new();
		radius = tbq_pkg::RAD_RESET;
		errors = 0;
		checked = 0;
	endfunction

	static function longint unsigned round_sqrt(longint unsigned n);
		longint unsigned res, bitv, rem;
		res = 0;
		bitv = 64'd1 << 62;
		rem = n;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		if (n - res * res > res) res++;
		return res;
	endfunction

	static function longint unsigned absval(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	static function longint sphere_height(longint x, longint y, longint unsigned r);
		longint unsigned d2, r2, dn;
		d2 = longint'(x * x) + longint'(y * y);
		r2 = r * r;
		if (2 * d2 < r2) return longint'(round_sqrt(r2 - d2));
		dn = round_sqrt(d2 << 30);
		if (dn == 0) return 0;
		return longint'(((r2 << 15) + dn) / (2 * dn));
	endfunction

	static function logic signed [15:0] clamp_q(longint v);
		longint one;
		one = 64'sd1 << tbq_pkg::FRAC_BITS;
		if (v > one) v = one;
		if (v < -one) v = -one;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	function tbq_pkg::tbq_quat_t rotation_of(tbq_pkg::tbq_point_t p);
		tbq_pkg::tbq_quat_t q;
		longint one, x1, y1, x2, y2, z1, z2, dx, dy, dz;
		longint ax[3];
		longint unsigned r, r2, asq, alen, dd, t, s, den, m;
		one = 64'sd1 << tbq_pkg::FRAC_BITS;
		x1 = p.start_x; y1 = p.start_y; x2 = p.end_x; y2 = p.end_y;
		r = radius;
		r2 = r * r;
		q.quat_x = 0; q.quat_y = 0; q.quat_z = 0;
		q.quat_w = clamp_q(one);
		q.no_rotation = 1'b1;
		if (x1 == x2 && y1 == y2) return q;
		z1 = sphere_height(x1, y1, r);
		z2 = sphere_height(x2, y2, r);
		ax[0] = y2 * z1 - z2 * y1;
		ax[1] = z2 * x1 - x2 * z1;
		ax[2] = x2 * y1 - y2 * x1;
		asq = 0;
		for (int i = 0; i < 3; i++) asq += absval(ax[i]) * absval(ax[i]);
		if (asq == 0) return q;
		alen = round_sqrt(asq);
		dx = x1 - x2; dy = y1 - y2; dz = z1 - z2;
		dd = absval(dx) * absval(dx) + absval(dy) * absval(dy) + absval(dz) * absval(dz);
		if (r == 0 || dd >= 4 * r2) begin
			t = one;
		end else begin
			s = round_sqrt(dd << 28);
			den = r << 15;
			t = ((s << tbq_pkg::FRAC_BITS) + den / 2) / den;
			if (t > one) t = one;
		end
		m = (t * absval(ax[0]) + alen / 2) / alen;
		q.quat_x = clamp_q(ax[0] < 0 ? longint'(m) : -longint'(m));
		m = (t * absval(ax[1]) + alen / 2) / alen;
		q.quat_y = clamp_q(ax[1] < 0 ? longint'(m) : -longint'(m));
		m = (t * absval(ax[2]) + alen / 2) / alen;
		q.quat_z = clamp_q(ax[2] < 0 ? longint'(m) : -longint'(m));
		q.quat_w = clamp_q(longint'(round_sqrt(longint'(one * one) - t * t)));
		q.no_rotation = 1'b0;
		return q;
	endfunction

	function void note_request(tbq_pkg::tbq_point_t p);
		pending.push_back(rotation_of(p));
	endfunction

	function void check_result(tbq_pkg::tbq_quat_t got);
		tbq_pkg::tbq_quat_t exp_q;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_q = pending.pop_front();
		checked++;
		if (got.quat_x !== exp_q.quat_x)
			$display("%0t: quat_x exp %0d got %0d", $time, exp_q.quat_x, got.quat_x);
		if (got.quat_y !== exp_q.quat_y)
			$display("%0t: quat_y exp %0d got %0d", $time, exp_q.quat_y, got.quat_y);
		if (got.quat_z !== exp_q.quat_z)
			$display("%0t: quat_z exp %0d got %0d", $time, exp_q.quat_z, got.quat_z);
		if (got.quat_w !== exp_q.quat_w)
			$display("%0t: quat_w exp %0d got %0d", $time, exp_q.quat_w, got.quat_w);
		if (got.no_rotation !== exp_q.no_rotation)
			$display("%0t: no_rotation exp %0d got %0d", $time, exp_q.no_rotation,
				got.no_rotation);
		if (got !== exp_q) errors++;
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_ready;
	tbq_pkg::tbq_point_t point = '0;
	logic quat_valid;
	logic quat_ready = 1'b0;
	tbq_pkg::tbq_quat_t quat;
	logic radius_we = 1'b0;
	logic [14:0] radius_wdata = '0;

	quat_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	int hold_n = 0;
	bit stall_free = 0;

	trackball_rotation_quaternion_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
		.radius_we(radius_we), .radius_wdata(radius_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random wait per result, checked on handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (quat_valid && quat_ready) begin
				sb.check_result(quat);
				hold_n = stall_free ? 0 : $urandom_range(0, 5);
			end else if (hold_n > 0) begin
				hold_n = hold_n - 1;
			end
			quat_ready <= (hold_n == 0);
		end
	end

	task automatic send_request(tbq_pkg::tbq_point_t p, bit gaps);
		int wait_n;
		wait_n = gaps ? $urandom_range(0, 5) : 0;
		if (wait_n > 0) begin
			point_valid <= 1'b0;
			repeat (wait_n) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		do @(posedge clk); while (!point_ready);
		sb.note_request(p);
		sent++;
	endtask

	task automatic send_pair(int sx, int sy, int ex, int ey);
		tbq_pkg::tbq_point_t p;
		p.start_x = 16'(sx); p.start_y = 16'(sy);
		p.end_x = 16'(ex); p.end_y = 16'(ey);
		send_request(p, 1'b1);
	endtask

	task automatic drain();
		point_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_radius(logic [14:0] r);
		drain();
		radius_we <= 1'b1;
		radius_wdata <= r;
		@(posedge clk);
		radius_we <= 1'b0;
		sb.radius = r;
	endtask

	task automatic random_drags(int count);
		tbq_pkg::tbq_point_t p;
		int span;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: p = tbq_pkg::tbq_point_t'({$urandom, $urandom});
				1: begin
					p.start_x = 16'($urandom); p.start_y = 16'($urandom);
					p.end_x = p.start_x; p.end_y = p.start_y;
				end
				default: begin
					span = $urandom_range(0, 3) == 0 ? 32767 : 2000;
					p.start_x = 16'($urandom_range(0, 32767) - 16384);
					p.start_y = 16'($urandom_range(0, 32767) - 16384);
					p.end_x = 16'(p.start_x + $urandom_range(0, 2 * span) - span);
					p.end_y = 16'(p.start_y + $urandom_range(0, 2 * span) - span);
				end
			endcase
			send_request(p, $urandom_range(0, 3) != 0);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: identity, extremes, axis through origin, large travel
		send_pair(0, 0, 0, 0);
		send_pair(-32768, -32768, -32768, -32768);
		send_pair(0, 0, 100, 0);
		send_pair(1000, 0, 2000, 0);
		send_pair(-32768, -32768, 32767, 32767);
		send_pair(32767, -32768, -32768, 32767);
		send_pair(16384, 0, 0, 16384);
		send_pair(0, 0, 0, 9267);
		send_pair(9267, 0, 9268, 1);
		send_pair(-5000, 3000, 4000, -2000);
		send_pair(1, 0, 0, 1);
		send_pair(32767, 32767, -1, -1);
		random_drags(300);
		// pause until every pending result is back
		drain();
		stall_free = 1;
		random_drags(100);
		stall_free = 0;
		set_radius(15'd1);
		send_pair(0, 0, 0, 1);
		send_pair(100, 0, -100, 0);
		random_drags(150);
		set_radius(15'd32767);
		send_pair(-32768, -32768, 32767, 32767);
		send_pair(0, 0, 16384, 0);
		random_drags(300);
		set_radius(15'h5555);
		random_drags(200);
		set_radius(15'h2AAA);
		random_drags(200);
		set_radius(15'd0);
		send_pair(0, 0, 100, 100);
		random_drags(50);
		set_radius(tbq_pkg::RAD_RESET);
		random_drags(100);
		drain();
		repeat (tbq_pkg::PIPE_LAT + 20) @(posedge clk);
		$display("sent %0d point pairs, checked %0d quaternions", sent, sb.checked);
		$display("radii covered: reset, 0, 1, 0x2aaa, 0x5555, max");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
src/tbq_pkg.sv
src/tbq_sqrt.sv
src/tbq_div.sv
src/tbq_delay.sv
src/tbq_lift.sv
src/trackball_rotation_quaternion_top.sv
test/tb.sv
